[rtl/core/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define CRBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CRBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/crbp_pkg.sv]
// Shared types, constants and helper functions of the crossing record bit packer.
package crbp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 11;
    localparam int PCNT_W    = $clog2(WORD_BITS);
    localparam int LEN_W     = $clog2(CNT_W + 2);
    localparam int REG_IDX_W = 1;
    localparam int CNT_LIMIT = (1 << CNT_W) - 1;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_CROSSING_COUNT = reg_idx_t'(0);
    localparam reg_idx_t REG_SIGNED_MODE    = reg_idx_t'(1);

    typedef struct packed {
        logic             crossing_sign;
        logic             head_flag_0;
        logic [IDX_W-1:0] edge_index_0;
        logic             head_flag_1;
        logic [IDX_W-1:0] edge_index_1;
        logic             head_flag_2;
        logic [IDX_W-1:0] edge_index_2;
        logic             head_flag_3;
        logic [IDX_W-1:0] edge_index_3;
    } crbp_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic                 last_word;
    } crbp_out_t;

    // Number of significant bits of v.
    function automatic logic [LEN_W-1:0] bit_len(input logic [CNT_W-1:0] v);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

[rtl/core/crbp_in_stage.sv]
// Input register stage holding one crossing word ahead of the packer.
module crbp_in_stage
    import crbp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  crbp_in_t s_data,
    input  logic     take,
    output logic     item_valid,
    output crbp_in_t item
);

    logic     valid_reg;
    logic     valid_next;
    crbp_in_t data_reg;
    logic     accept;

    assign s_ready    = !valid_reg || take;
    assign accept     = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data;
        end
    end

endmodule

[rtl/core/crbp_packer.sv]
// Configuration registers, stream state and single-pass record packing.
module crbp_packer
    import crbp_pkg::*;
#(
    parameter int MAX_CROSSINGS = 1024,
    parameter int RES_MAX       = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  reg_idx_t                     cfg_index,
    input  logic [CNT_W-1:0]             cfg_wdata,
    input  crbp_in_t                     item,
    input  logic                         go,
    output logic [$clog2(RES_MAX+1)-1:0] res_cnt,
    output crbp_out_t                    res [RES_MAX]
);

    localparam int NMAX     = (MAX_CROSSINGS < CNT_LIMIT) ? MAX_CROSSINGS : CNT_LIMIT;
    localparam int WMAX     = $clog2(2 * NMAX);
    localparam int REC_W    = 1 + 4 * (1 + WMAX);
    localparam int MAX_FULL = (WORD_BITS - 1 + REC_W) / WORD_BITS;
    localparam int CAT_W    = (MAX_FULL + 1) * WORD_BITS;
    localparam int POS_W    = $clog2(REC_W + 1);
    localparam int TOT_W    = $clog2(CAT_W + 1);
    localparam int FULL_W   = $clog2(MAX_FULL + 1);
    localparam int RCNT_W   = $clog2(RES_MAX + 1);
    localparam int IX_W     = $clog2(RES_MAX);

    logic [CNT_W-1:0]     cc_reg;
    logic                 sm_reg;
    logic [WORD_BITS-1:0] pend_reg;
    logic [WORD_BITS-1:0] pend_next;
    logic [PCNT_W-1:0]    pcnt_reg;
    logic [PCNT_W-1:0]    pcnt_next;
    logic [CNT_W-1:0]     done_reg;
    logic [CNT_W-1:0]     done_next;

    logic [CNT_W-1:0]     n_raw;
    logic [CNT_W-1:0]     n_eff;
    logic [LEN_W-1:0]     w;
    logic [LEN_W:0]       step;
    logic [IDX_W-1:0]     imask;
    logic                 flags [4];
    logic [IDX_W-1:0]     idxs [4];
    logic [REC_W-1:0]     rec;
    logic [POS_W-1:0]     pos;
    logic [POS_W-1:0]     rec_len;
    logic [TOT_W-1:0]     total;
    logic [FULL_W-1:0]    full;
    logic [PCNT_W-1:0]    rem;
    logic [CAT_W-1:0]     cat;
    logic [WORD_BITS-1:0] left;
    logic [WORD_BITS-1:0] hdr;
    logic                 ends;
    logic [RCNT_W-1:0]    rcnt;
    logic [RCNT_W-1:0]    rlast;

    assign n_raw = (cc_reg == '0) ? CNT_W'(1) : cc_reg;
    assign n_eff = (n_raw > CNT_W'(NMAX)) ? CNT_W'(NMAX) : n_raw;
    assign w     = bit_len(n_eff - CNT_W'(1)) + LEN_W'(1);
    assign step  = (LEN_W+1)'(w) + (LEN_W+1)'(1);
    assign imask = ~({IDX_W{1'b1}} << w);

    assign flags[0] = item.head_flag_0;
    assign flags[1] = item.head_flag_1;
    assign flags[2] = item.head_flag_2;
    assign flags[3] = item.head_flag_3;
    assign idxs[0]  = item.edge_index_0;
    assign idxs[1]  = item.edge_index_1;
    assign idxs[2]  = item.edge_index_2;
    assign idxs[3]  = item.edge_index_3;

    always_comb begin
        rec    = '0;
        rec[0] = sm_reg & item.crossing_sign;
        pos    = POS_W'(sm_reg);
        for (int k = 0; k < 4; k++) begin
            rec = rec | (REC_W'(flags[k]) << pos);
            rec = rec | (REC_W'(idxs[k] & imask) << (pos + POS_W'(1)));
            pos = pos + POS_W'(step);
        end
        rec_len = pos;
    end

    assign total = TOT_W'(pcnt_reg) + TOT_W'(rec_len);
    assign full  = FULL_W'(total / WORD_BITS);
    assign rem   = PCNT_W'(total % WORD_BITS);
    assign cat   = CAT_W'(pend_reg) | (CAT_W'(rec) << pcnt_reg);
    assign hdr   = sm_reg ? (WORD_BITS'(0) - WORD_BITS'(n_eff)) : WORD_BITS'(n_eff);
    assign ends  = ((CNT_W+1)'(done_reg) + (CNT_W+1)'(1)) >= (CNT_W+1)'(n_eff);

    always_comb begin
        left = '0;
        for (int j = 0; j <= MAX_FULL; j++) begin
            if (full == FULL_W'(j)) begin
                left = cat[j*WORD_BITS +: WORD_BITS];
            end
        end
    end

    always_comb begin
        rcnt = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            res[i] = '0;
        end
        if (done_reg == '0) begin
            res[rcnt[IX_W-1:0]] = '{packed_word: hdr, last_word: 1'b0};
            rcnt = rcnt + RCNT_W'(1);
        end
        for (int j = 0; j < MAX_FULL; j++) begin
            if (FULL_W'(j) < full) begin
                res[rcnt[IX_W-1:0]] = '{packed_word: cat[j*WORD_BITS +: WORD_BITS],
                                        last_word: 1'b0};
                rcnt = rcnt + RCNT_W'(1);
            end
        end
        rlast = rcnt - RCNT_W'(1);
        if (ends && rem != '0) begin
            res[rcnt[IX_W-1:0]] = '{packed_word: left, last_word: 1'b1};
            rcnt = rcnt + RCNT_W'(1);
        end else if (ends && rcnt != '0) begin
            res[rlast[IX_W-1:0]].last_word = 1'b1;
        end
        res_cnt = rcnt;
    end

    always_comb begin
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        done_next = done_reg;
        if (go) begin
            if (ends) begin
                pend_next = '0;
                pcnt_next = '0;
                done_next = '0;
            end else begin
                pend_next = left;
                pcnt_next = rem;
                done_next = done_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg   <= CNT_W'(1);
            sm_reg   <= 1'b0;
            pend_reg <= '0;
            pcnt_reg <= '0;
            done_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            done_reg <= done_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_CROSSING_COUNT: cc_reg <= cfg_wdata;
                    REG_SIGNED_MODE:    sm_reg <= cfg_wdata[0];
                endcase
            end
        end
    end

endmodule

[rtl/core/crbp_out_buf.sv]
// Result buffer that holds one item's words and hands them out one per cycle while m_ready is high.
module crbp_out_buf
    import crbp_pkg::*;
#(
    parameter int RES_MAX = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [$clog2(RES_MAX+1)-1:0] load_cnt,
    input  crbp_out_t                    load_data [RES_MAX],
    output logic                         can_load,
    output logic                         m_valid,
    input  logic                         m_ready,
    output crbp_out_t                    m_data
);

    localparam int RCNT_W = $clog2(RES_MAX + 1);
    localparam int IX_W   = $clog2(RES_MAX);

    crbp_out_t         words_reg [RES_MAX];
    logic [IX_W-1:0]   head_reg;
    logic [IX_W-1:0]   head_next;
    logic [RCNT_W-1:0] cnt_reg;
    logic [RCNT_W-1:0] cnt_next;
    logic              pop;

    assign m_valid  = cnt_reg != '0;
    assign m_data   = words_reg[head_reg];
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == '0) || (cnt_reg == RCNT_W'(1) && m_ready);

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            head_next = '0;
            cnt_next  = load_cnt;
        end else if (pop) begin
            head_next = head_reg + IX_W'(1);
            cnt_next  = cnt_reg - RCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < RES_MAX; i++) begin
                words_reg[i] <= load_data[i];
            end
        end
    end

endmodule

[rtl/core/crossing_record_bit_packer_core.sv]
// Top level of the crossing record bit packer.
//
//  channel  ports                      payload      carries
//  s_       s_valid s_ready s_data     crbp_in_t    one crossing record
//  m_       m_valid m_ready m_data     crbp_out_t   header or stream word
//  cfg_     cfg_wr_en cfg_index        11 bits      crossing_count, signed_mode
//
// An item is registered in the input stage, is packed in one pass into
// the result buffer, and its first word shows on m_ the cycle after packing.
// The result buffer sends one word per cycle while m_ready is high, with up
// to four words per item counting the header and the final word.
// Reset is synchronous and clears configuration to count 1, unsigned.
// A stall on m_ holds the buffer; the input register still takes one word.
module crossing_record_bit_packer_core
    import crbp_pkg::*;
#(
    parameter int MAX_CROSSINGS = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  reg_idx_t         cfg_index,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  crbp_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output crbp_out_t        m_data
);

    localparam int NMAX     = (MAX_CROSSINGS < CNT_LIMIT) ? MAX_CROSSINGS : CNT_LIMIT;
    localparam int WMAX     = $clog2(2 * NMAX);
    localparam int REC_W    = 1 + 4 * (1 + WMAX);
    localparam int MAX_FULL = (WORD_BITS - 1 + REC_W) / WORD_BITS;
    localparam int RES_MAX  = MAX_FULL + 2;
    localparam int RCNT_W   = $clog2(RES_MAX + 1);

    logic              item_valid;
    crbp_in_t          item;
    logic              can_load;
    logic              go;
    logic [RCNT_W-1:0] res_cnt;
    crbp_out_t         res [RES_MAX];

    assign go = item_valid && can_load;

    crbp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (go),
        .item_valid (item_valid),
        .item       (item)
    );

    crbp_packer #(
        .MAX_CROSSINGS (MAX_CROSSINGS),
        .RES_MAX       (RES_MAX)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .go        (go),
        .res_cnt   (res_cnt),
        .res       (res)
    );

    crbp_out_buf #(
        .RES_MAX (RES_MAX)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (go),
        .load_cnt  (res_cnt),
        .load_data (res),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/core/crbp_checker.sv]
// Port-level checker for the crossing record bit packer and its bind.
`include "assert_macros.svh"

module crbp_checker
    import crbp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input crbp_out_t m_data
);

    `CRBP_ASSERT(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word changed")
    `CRBP_ASSERT_ALWAYS(a_rst_m_idle, aclk, !aresetn |=> !m_valid, "word valid after reset")
    `CRBP_ASSERT_ALWAYS(a_rst_s_ready, aclk, !aresetn |=> s_ready, "input not ready after reset")
    `CRBP_ASSERT(a_empty_ready, aclk, aresetn, !m_valid |-> s_ready, "input blocked with no word pending")

endmodule

bind crossing_record_bit_packer_core crbp_checker u_crbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/sv/tb_crossing_record_bit_packer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the crossing record bit packer core.
module tb_crossing_record_bit_packer_core;
    import crbp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_COUNT     = 1024;
    localparam int PHASE_ITEMS   = 49;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    reg_idx_t         cfg_index = REG_CROSSING_COUNT;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    crbp_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    crbp_out_t        m_data;

    crossing_record_bit_packer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [CNT_W-1:0]     model_count      = CNT_W'(1);
    logic                 model_signed     = 1'b0;
    logic [WORD_BITS-1:0] acc_bits         = '0;
    int unsigned          acc_cnt          = 0;
    int unsigned          crossings_packed = 0;
    int unsigned          item_words       = 0;

    crbp_in_t    crossing_q[$];
    crbp_out_t   packed_words_due[$];
    crbp_out_t   due_word;
    int unsigned mismatches = 0;
    bit          idle_on    = 1'b1;
    int unsigned src_gap    = 0;
    int unsigned sink_stall = 0;

    function automatic void put_word(input logic [WORD_BITS-1:0] w, input logic last);
        crbp_out_t o;
        o.packed_word = w;
        o.last_word   = last;
        packed_words_due.push_back(o);
        item_words++;
    endfunction

    function automatic void put_bit(input logic b);
        acc_bits[acc_cnt] = b;
        acc_cnt++;
        if (acc_cnt == WORD_BITS) begin
            put_word(acc_bits, 1'b0);
            acc_bits = '0;
            acc_cnt  = 0;
        end
    endfunction

    function automatic void pack_crossing(input crbp_in_t rec);
        int unsigned      n;
        int unsigned      iw;
        logic [IDX_W-1:0] idx [4];
        logic             flag [4];
        crbp_out_t        tail;
        n = model_count;
        if (n < 1) n = 1;
        if (n > MAX_COUNT) n = MAX_COUNT;
        iw = 0;
        while ((1 << iw) < 2 * n) iw++;
        idx  = '{rec.edge_index_0, rec.edge_index_1, rec.edge_index_2, rec.edge_index_3};
        flag = '{rec.head_flag_0, rec.head_flag_1, rec.head_flag_2, rec.head_flag_3};
        item_words = 0;
        if (crossings_packed == 0) begin
            put_word(model_signed ? (WORD_BITS'(0) - WORD_BITS'(n)) : WORD_BITS'(n), 1'b0);
        end
        if (model_signed) begin
            put_bit(rec.crossing_sign);
        end
        for (int k = 0; k < 4; k++) begin
            put_bit(flag[k]);
            for (int i = 0; i < iw; i++) begin
                put_bit(idx[k][i]);
            end
        end
        if (crossings_packed + 1 >= n) begin
            if (acc_cnt > 0) begin
                put_word(acc_bits, 1'b1);
            end else if (item_words > 0) begin
                tail = packed_words_due.pop_back();
                tail.last_word = 1'b1;
                packed_words_due.push_back(tail);
            end
            acc_bits         = '0;
            acc_cnt          = 0;
            crossings_packed = 0;
        end else begin
            crossings_packed++;
        end
    endfunction

    function automatic crbp_in_t make_crossing(input logic sgn, input logic [3:0] flags,
                                               input logic [IDX_W-1:0] i0, input logic [IDX_W-1:0] i1,
                                               input logic [IDX_W-1:0] i2, input logic [IDX_W-1:0] i3);
        crbp_in_t c;
        c.crossing_sign = sgn;
        c.head_flag_0   = flags[0];
        c.edge_index_0  = i0;
        c.head_flag_1   = flags[1];
        c.edge_index_1  = i1;
        c.head_flag_2   = flags[2];
        c.edge_index_2  = i2;
        c.head_flag_3   = flags[3];
        c.edge_index_3  = i3;
        return c;
    endfunction

    function automatic crbp_in_t random_crossing();
        logic [63:0] r;
        crbp_in_t    c;
        r = {$urandom, $urandom};
        c = r[$bits(crbp_in_t)-1:0];
        case ($urandom_range(0, 7))
            0: begin
                c.edge_index_0 = '0;
                c.edge_index_1 = '0;
                c.edge_index_2 = '0;
                c.edge_index_3 = '0;
            end
            1: begin
                c.edge_index_0 = '1;
                c.edge_index_1 = '1;
                c.edge_index_2 = '1;
                c.edge_index_3 = '1;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return MAX_COUNT;
            2: return $urandom_range(MAX_COUNT + 1, CNT_LIMIT);
            3: return 1;
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CROSSING_COUNT) begin
            model_count = val;
        end else begin
            model_signed = val[0];
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (crossing_q.size() != 0 || s_valid || packed_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pack_crossing(s_data);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (crossing_q.size() > 0) begin
                    s_data  <= crossing_q.pop_front();
                    s_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0) begin
                        src_gap = $urandom_range(1, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (packed_words_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected word: packed_word %h last_word %b",
                                 m_data.packed_word, m_data.last_word);
                    end
                    mismatches++;
                end else begin
                    due_word = packed_words_due.pop_front();
                    if (m_data.packed_word !== due_word.packed_word ||
                        m_data.last_word !== due_word.last_word) begin
                        if (mismatches < 10) begin
                            $display("mismatch: packed_word exp %h got %h, last_word exp %b got %b",
                                     due_word.packed_word, m_data.packed_word,
                                     due_word.last_word, m_data.last_word);
                        end
                        mismatches++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) begin
                    sink_stall = $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        int unsigned cnt;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        crossing_q.push_back(make_crossing(1'b0, 4'b0000, 11'd0, 11'd0, 11'd0, 11'd0));
        crossing_q.push_back(make_crossing(1'b1, 4'b1111, 11'd2047, 11'd2047, 11'd2047, 11'd2047));
        crossing_q.push_back(make_crossing(1'b0, 4'b0101, 11'h555, 11'h2aa, 11'd1, 11'd1024));
        drain();

        write_reg(REG_CROSSING_COUNT, CNT_W'(0));
        write_reg(REG_SIGNED_MODE, CNT_W'(1));
        crossing_q.push_back(make_crossing(1'b0, 4'b0000, 11'd0, 11'd0, 11'd0, 11'd0));
        crossing_q.push_back(make_crossing(1'b1, 4'b1111, 11'd2047, 11'd2047, 11'd2047, 11'd2047));
        crossing_q.push_back(make_crossing(1'b1, 4'b1010, 11'h2aa, 11'h555, 11'd1024, 11'd1));
        drain();

        // four 16-bit records end exactly on a word boundary
        write_reg(REG_CROSSING_COUNT, CNT_W'(4));
        write_reg(REG_SIGNED_MODE, CNT_W'(0));
        repeat (4) crossing_q.push_back(random_crossing());
        drain();

        write_reg(REG_CROSSING_COUNT, CNT_W'(CNT_LIMIT));
        write_reg(REG_SIGNED_MODE, CNT_W'(1));
        repeat (5) crossing_q.push_back(random_crossing());
        drain();

        // shrink the count mid-code
        write_reg(REG_CROSSING_COUNT, CNT_W'(3));
        repeat (2) crossing_q.push_back(random_crossing());
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 7) idle_on = 1'b0;
            cnt = (p == 0) ? MAX_COUNT : pick_count();
            write_reg(REG_CROSSING_COUNT, CNT_W'(cnt));
            write_reg(REG_SIGNED_MODE, (p == 0) ? CNT_W'(0) : CNT_W'($urandom_range(0, 1)));
            repeat (PHASE_ITEMS) crossing_q.push_back(random_crossing());
            drain();
        end

        if (mismatches == 0 && packed_words_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
